FILE: hdl/spt_pkg.sv
// shared constants, types and codes of the sorted position table
`default_nettype none
package spt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 16;
  localparam int POS_W       = 24;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int ECOUNT_W    = 7;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 72;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic apply;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hdl/sorted_position_table.sv
// Sorted position table: keeps up to 64 vehicle ids ordered by lane position
// (unsigned, 8 fractional bits). Each transaction is an insert, a remove by id
// or a neighbor query, and yields one result transaction. An item passes a
// compare state, in which every cell compares its key against the broadcast
// key, and an apply state, in which the cells shift and the result register
// loads once the result side has room. A new item is taken in the cycle the
// previous one finishes, so only one item is in flight at a time. Inserting
// into a full table returns status 1; removing an absent id returns status 2;
// equal positions keep arrival order and a remove hits the lowest-placed match.
`default_nettype none
module sorted_position_table (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [spt_pkg::IN_DATA_W-1:0]  in_tdata,   // vehicle_id, position
  input  wire logic [spt_pkg::OP_W-1:0]       in_tuser,   // operation
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [spt_pkg::OUT_DATA_W-1:0]      out_tdata,  // ahead_found, ahead_id,
                                                          // behind_found, behind_id,
                                                          // gap_ahead, entry_count, zero pad
  output logic [spt_pkg::STATUS_W-1:0]        out_tuser   // status
);

  spt_pkg::cmd_t cmd;

  spt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

FILE: hdl/spt_ctrl.sv
// controller: sequences load, compare and apply and owns the handshakes
`default_nettype none
module spt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output spt_pkg::cmd_t     cmd
);

  spt_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            room;
  logic            accept;

  assign room   = !out_valid_r || out_tready;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spt_pkg::S_IDLE: begin
        if (accept) state_nxt = spt_pkg::S_CMP;
      end
      spt_pkg::S_CMP: begin
        state_nxt = spt_pkg::S_APPLY;
      end
      spt_pkg::S_APPLY: begin
        if (room) state_nxt = accept ? spt_pkg::S_CMP : spt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      spt_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      spt_pkg::S_CMP: begin
        cmd.cmp = 1'b1;
      end
      spt_pkg::S_APPLY: begin
        in_tready = room;
        cmd.apply = room;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    cmd.load = in_tvalid && in_tready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.apply) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/spt_datapath.sv
// datapath: row of sorted cells with broadcast compare, shift and neighbor select
`default_nettype none
module spt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire spt_pkg::cmd_t                    cmd,
  input  wire logic [spt_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [spt_pkg::OP_W-1:0]         in_tuser,
  output logic      [spt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic      [spt_pkg::STATUS_W-1:0]     out_tuser
);

  localparam int N = spt_pkg::MAX_ENTRIES;

  logic [spt_pkg::POS_W-1:0]   pos_r [N];
  logic [spt_pkg::ID_W-1:0]    id_r  [N];
  logic [spt_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic [spt_pkg::OP_W-1:0]    op_r;
  logic [spt_pkg::ID_W-1:0]    key_id_r;
  logic [spt_pkg::POS_W-1:0]   key_pos_r;

  logic [N-1:0] valid_r, le_r, lt_r, match_r;
  logic [N-1:0] le_prev, lt_next, seen_incl, ahead_hot, behind_hot;

  logic                        full, any_match, do_insert, do_remove;
  logic [spt_pkg::ID_W-1:0]    ahead_id, behind_id;
  logic [spt_pkg::POS_W-1:0]   ahead_pos;

  spt_pkg::status_t            status_r;
  logic                        ahead_found_r, behind_found_r;
  logic [spt_pkg::ID_W-1:0]    ahead_id_r, behind_id_r;
  logic [spt_pkg::POS_W-1:0]   gap_r;
  logic [spt_pkg::ECOUNT_W-1:0] ecount_r;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_tuser;
      key_id_r  <= in_tdata[spt_pkg::ID_W-1:0];
      key_pos_r <= in_tdata[spt_pkg::ID_W +: spt_pkg::POS_W];
    end
  end

  // broadcast compare against every cell
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      for (int i = 0; i < N; i++) begin
        valid_r[i] <= spt_pkg::COUNT_W'(i) < count_r;
        le_r[i]    <= (spt_pkg::COUNT_W'(i) < count_r) && (pos_r[i] <= key_pos_r);
        lt_r[i]    <= (spt_pkg::COUNT_W'(i) < count_r) && (pos_r[i] < key_pos_r);
        match_r[i] <= (spt_pkg::COUNT_W'(i) < count_r) && (id_r[i] == key_id_r);
      end
    end
  end

  assign le_prev = {le_r[N-2:0], 1'b1};
  assign lt_next = {1'b0, lt_r[N-1:1]};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      seen_incl[i]  = |(match_r & ((N'(1) << i) | ((N'(1) << i) - N'(1))));
      ahead_hot[i]  = valid_r[i] && le_prev[i] && !le_r[i];
      behind_hot[i] = lt_r[i] && !lt_next[i];
    end
  end

  // one-hot neighbor select
  always_comb begin
    ahead_id  = '0;
    behind_id = '0;
    ahead_pos = '0;
    for (int i = 0; i < N; i++) begin
      ahead_id  = ahead_id  | (ahead_hot[i]  ? id_r[i]  : '0);
      ahead_pos = ahead_pos | (ahead_hot[i]  ? pos_r[i] : '0);
      behind_id = behind_id | (behind_hot[i] ? id_r[i]  : '0);
    end
  end

  assign full      = count_r == spt_pkg::COUNT_W'(N);
  assign any_match = |match_r;
  assign do_insert = cmd.apply && (op_r == spt_pkg::OP_INSERT) && !full;
  assign do_remove = cmd.apply && (op_r == spt_pkg::OP_REMOVE) && any_match;

  always_comb begin
    count_nxt = count_r;
    if (do_insert) count_nxt = count_r + spt_pkg::COUNT_W'(1);
    if (do_remove) count_nxt = count_r - spt_pkg::COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [spt_pkg::POS_W-1:0] pos_dn, pos_up;
    logic [spt_pkg::ID_W-1:0]  id_dn, id_up;
    if (g == 0) begin : g_first
      assign pos_dn = key_pos_r;
      assign id_dn  = key_id_r;
    end else begin : g_mid
      assign pos_dn = pos_r[g-1];
      assign id_dn  = id_r[g-1];
    end
    if (g == N - 1) begin : g_last
      assign pos_up = pos_r[g];
      assign id_up  = id_r[g];
    end else begin : g_inner
      assign pos_up = pos_r[g+1];
      assign id_up  = id_r[g+1];
    end
    always_ff @(posedge clk) begin
      if (do_insert && !le_r[g]) begin
        if (le_prev[g]) begin
          pos_r[g] <= key_pos_r;
          id_r[g]  <= key_id_r;
        end else begin
          pos_r[g] <= pos_dn;
          id_r[g]  <= id_dn;
        end
      end else if (do_remove && seen_incl[g]) begin
        pos_r[g] <= pos_up;
        id_r[g]  <= id_up;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_r       <= spt_pkg::ST_OK;
      ahead_found_r  <= 1'b0;
      ahead_id_r     <= '0;
      behind_found_r <= 1'b0;
      behind_id_r    <= '0;
      gap_r          <= '0;
      ecount_r       <= spt_pkg::ECOUNT_W'(count_nxt);
      case (op_r)
        spt_pkg::OP_INSERT: begin
          if (full) status_r <= spt_pkg::ST_FULL;
        end
        spt_pkg::OP_REMOVE: begin
          if (!any_match) status_r <= spt_pkg::ST_MISSING;
        end
        spt_pkg::OP_QUERY: begin
          ahead_found_r  <= |ahead_hot;
          ahead_id_r     <= ahead_id;
          behind_found_r <= |behind_hot;
          behind_id_r    <= behind_id;
          gap_r          <= (|ahead_hot) ? (ahead_pos - key_pos_r) : '0;
        end
        default: begin
          status_r <= spt_pkg::ST_OK;
        end
      endcase
    end
  end

  assign out_tuser = status_r;
  assign out_tdata = {7'd0, ecount_r, gap_r, behind_id_r, behind_found_r,
                      ahead_id_r, ahead_found_r};

endmodule
`default_nettype wire

FILE: hdl/spt_checker.sv
// port-level checker for the sorted position table and its bind
`default_nettype none
module spt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [spt_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [spt_pkg::STATUS_W-1:0]   out_tuser
);

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // compare cycle follows every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("transaction accepted during compare cycle");

  // status code in range
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unknown status code");

  // count never above table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[64:58] <= 7'(spt_pkg::MAX_ENTRIES))
    else $error("entry count above table depth");

endmodule

bind sorted_position_table spt_checker u_spt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
